FILE: rtl/hpma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpma_pkg: shared types and constants for the hit/plane match and align unit
// Field widths, table depth, action and mode codes, token and result structs.
// ----------------------------------------------------------------------------
package hpma_pkg;

  localparam int MAX_PLANES      = 8;
  localparam int ANGLE_FRAC_BITS = 24;

  localparam int POS_W      = 28;
  localparam int ANG_W      = 24;
  localparam int ID_W       = 8;
  localparam int SLOT_W     = 3;
  localparam int WIN_W      = 27;
  localparam int MODE_W     = 2;
  localparam int PIU_W      = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 27;

  localparam int Q_W    = POS_W + 1;     // shifted position, kept exact
  localparam int DIST_W = POS_W + 1;
  localparam int PROD_W = ANG_W + Q_W;
  localparam int ACC_W  = PROD_W + 2;    // two products plus rounding half
  localparam int SUM_W  = ACC_W + 2;

  localparam logic signed [ACC_W-1:0] RND_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (ANGLE_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] POS_MAX_S =
    SUM_W'({1'b0, {(POS_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] POS_MIN_S =
    -SUM_W'({1'b1, {(POS_W-1){1'b0}}});

  localparam logic [CFG_ADDR_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PLANES = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW = 2'd2;

  typedef enum logic [1:0] {
    ACT_LOAD_Z   = 2'd0,
    ACT_LOAD_OFS = 2'd1,
    ACT_LOAD_ANG = 2'd2,
    ACT_HIT      = 2'd3
  } action_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_SHIFT     = 2'd0,
    MODE_ROT_SHIFT = 2'd1,
    MODE_SHIFT_ROT = 2'd2,
    MODE_NONE      = 2'd3
  } corr_mode_e;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  // hit travelling down the cell chain, carrying the best plane so far
  typedef struct packed {
    logic              vld;
    pos_t              px;
    pos_t              py;
    pos_t              pz;
    logic              found;
    logic [DIST_W-1:0] best_dz;
    logic [ID_W-1:0]   sensor;
    logic              hc;
    pos_t              ox;
    pos_t              oy;
    pos_t              oz;
    ang_t              aa;
    ang_t              ab;
    ang_t              ag;
  } hit_tok_t;

  typedef struct packed {
    action_e         action;
    logic [ID_W-1:0] sensor;
    pos_t            px;
    pos_t            py;
    pos_t            pz;
    ang_t            aa;
    ang_t            ab;
    ang_t            ag;
  } plane_ld_t;

  typedef struct packed {
    pos_t            x;
    pos_t            y;
    pos_t            z;
    logic [ID_W-1:0] sensor;
    logic            aligned;
    logic            status;
  } hit_res_t;

  function automatic pos_t sat_pos(input logic signed [SUM_W-1:0] v);
    pos_t r;
    if (v > POS_MAX_S) begin
      r = POS_MAX_S[POS_W-1:0];
    end else if (v < POS_MIN_S) begin
      r = POS_MIN_S[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/hpma_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpma_cell: one plane slot of the search chain
// Holds a slot's constants; compares the passing hit against its plane z.
// ----------------------------------------------------------------------------
module hpma_cell import hpma_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      we_i,
  input  plane_ld_t ld_i,
  input  logic      en_i,
  input  hit_tok_t  tok_i,
  output hit_tok_t  tok_o
);

  pos_t            z_q, ox_q, oy_q, oz_q;
  ang_t            aa_q, ab_q, ag_q;
  logic [ID_W-1:0] id_q;
  logic            hc_q;
  hit_tok_t        tok_q, tok_d;

  logic signed [DIST_W-1:0] dz;
  logic [DIST_W-1:0]        dz_abs;
  logic                     take;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      unique case (ld_i.action)
        ACT_LOAD_Z: begin
          id_q <= ld_i.sensor;
          z_q  <= ld_i.pz;
        end
        ACT_LOAD_OFS: begin
          ox_q <= ld_i.px;
          oy_q <= ld_i.py;
          oz_q <= ld_i.pz;
        end
        ACT_LOAD_ANG: begin
          aa_q <= ld_i.aa;
          ab_q <= ld_i.ab;
          ag_q <= ld_i.ag;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= 1'b0;
    end else if (we_i && ld_i.action == ACT_LOAD_OFS) begin
      hc_q <= 1'b1;
    end
  end

  always_comb begin
    dz     = DIST_W'(tok_i.pz) - DIST_W'(z_q);
    dz_abs = dz[DIST_W-1] ? DIST_W'(-dz) : DIST_W'(dz);
    take   = en_i && (!tok_i.found || dz_abs < tok_i.best_dz);
    tok_d  = tok_i;
    if (take) begin
      tok_d.found   = 1'b1;
      tok_d.best_dz = dz_abs;
      tok_d.sensor  = id_q;
      tok_d.hc      = hc_q;
      tok_d.ox      = ox_q;
      tok_d.oy      = oy_q;
      tok_d.oz      = oz_q;
      tok_d.aa      = aa_q;
      tok_d.ab      = ab_q;
      tok_d.ag      = ag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: rtl/hpma_corr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpma_corr: alignment correction sequencer
// Window check, offset shift and small-angle rotation on one shared multiplier.
// ----------------------------------------------------------------------------
module hpma_corr import hpma_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hit_tok_t         tok_i,
  input  corr_mode_e       mode_i,
  input  logic [WIN_W-1:0] window_i,
  output hit_res_t         res_o,
  output logic             res_vld_o,
  input  logic             res_rdy_i
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_FIN, S_HOLD} state_e;

  state_e          state_q;
  logic [2:0]      step_q;
  pos_t            p_q [3];
  pos_t            o_q [3];
  logic signed [Q_W-1:0]    qv_q [3];
  logic signed [ACC_W-1:0]  s_q [3];
  ang_t            aa_q, ab_q, ag_q;
  logic signed [PROD_W-1:0] prod_q;
  logic            pneg_q, pv_q;
  logic [1:0]      pdst_q;
  corr_mode_e      mode_q;
  logic            pass_q, zero_q, status_q;
  logic [ID_W-1:0] sensor_q;
  hit_res_t        res_q;

  logic                     status_c, pass_c, zero_c, rot_c;
  ang_t                     ang_sel;
  logic signed [Q_W-1:0]    q_sel;
  logic                     neg_sel;
  logic [1:0]               dst_sel;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [ACC_W-1:0]  sh;
  logic signed [SUM_W-1:0]  rot, sft;
  pos_t                     r_c [3];

  always_comb begin
    status_c = !tok_i.found || (tok_i.best_dz > DIST_W'(window_i));
    pass_c   = status_c || !tok_i.hc;
    zero_c   = !pass_c && mode_i == MODE_NONE;
    rot_c    = !pass_c && (mode_i == MODE_ROT_SHIFT || mode_i == MODE_SHIFT_ROT);
  end

  // product schedule: x gets g*y + b*z, y gets -g*x + a*z, z gets -b*x + a*y
  always_comb begin
    unique case (step_q)
      3'd0:    begin ang_sel = ag_q; q_sel = qv_q[1]; neg_sel = 1'b0; dst_sel = 2'd0; end
      3'd1:    begin ang_sel = ab_q; q_sel = qv_q[2]; neg_sel = 1'b0; dst_sel = 2'd0; end
      3'd2:    begin ang_sel = ag_q; q_sel = qv_q[0]; neg_sel = 1'b1; dst_sel = 2'd1; end
      3'd3:    begin ang_sel = aa_q; q_sel = qv_q[2]; neg_sel = 1'b0; dst_sel = 2'd1; end
      3'd4:    begin ang_sel = ab_q; q_sel = qv_q[0]; neg_sel = 1'b1; dst_sel = 2'd2; end
      3'd5:    begin ang_sel = aa_q; q_sel = qv_q[1]; neg_sel = 1'b0; dst_sel = 2'd2; end
      default: begin ang_sel = '0;   q_sel = '0;      neg_sel = 1'b0; dst_sel = 2'd0; end
    endcase
    prod_c = PROD_W'(ang_sel) * PROD_W'(q_sel);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh  = (s_q[i] + RND_HALF) >>> ANGLE_FRAC_BITS;
      rot = SUM_W'(qv_q[i]) + SUM_W'(sh);
      sft = SUM_W'(p_q[i]) - SUM_W'(o_q[i]);
      priority if (pass_q) begin
        r_c[i] = p_q[i];
      end else if (zero_q) begin
        r_c[i] = '0;
      end else if (mode_q == MODE_SHIFT) begin
        r_c[i] = sat_pos(sft);
      end else if (mode_q == MODE_ROT_SHIFT) begin
        r_c[i] = sat_pos(rot - SUM_W'(o_q[i]));
      end else begin
        r_c[i] = sat_pos(rot);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      pv_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (tok_i.vld) begin
            p_q[0]   <= tok_i.px;
            p_q[1]   <= tok_i.py;
            p_q[2]   <= tok_i.pz;
            o_q[0]   <= tok_i.ox;
            o_q[1]   <= tok_i.oy;
            o_q[2]   <= tok_i.oz;
            aa_q     <= tok_i.aa;
            ab_q     <= tok_i.ab;
            ag_q     <= tok_i.ag;
            if (mode_i == MODE_SHIFT_ROT) begin
              qv_q[0] <= Q_W'(tok_i.px) - Q_W'(tok_i.ox);
              qv_q[1] <= Q_W'(tok_i.py) - Q_W'(tok_i.oy);
              qv_q[2] <= Q_W'(tok_i.pz) - Q_W'(tok_i.oz);
            end else begin
              qv_q[0] <= Q_W'(tok_i.px);
              qv_q[1] <= Q_W'(tok_i.py);
              qv_q[2] <= Q_W'(tok_i.pz);
            end
            for (int i = 0; i < 3; i++) s_q[i] <= '0;
            mode_q   <= mode_i;
            pass_q   <= pass_c;
            zero_q   <= zero_c;
            status_q <= status_c;
            sensor_q <= tok_i.found ? tok_i.sensor : '0;
            step_q   <= '0;
            pv_q     <= 1'b0;
            state_q  <= rot_c ? S_MUL : S_FIN;
          end
        end
        S_MUL: begin
          if (pv_q) begin
            s_q[pdst_q] <= pneg_q ? s_q[pdst_q] - ACC_W'(prod_q)
                                  : s_q[pdst_q] + ACC_W'(prod_q);
          end
          if (step_q != 3'd6) begin
            prod_q <= prod_c;
            pneg_q <= neg_sel;
            pdst_q <= dst_sel;
            pv_q   <= 1'b1;
            step_q <= step_q + 3'd1;
          end else begin
            pv_q    <= 1'b0;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          res_q.x       <= r_c[0];
          res_q.y       <= r_c[1];
          res_q.z       <= r_c[2];
          res_q.sensor  <= sensor_q;
          res_q.aligned <= !pass_q && !zero_q;
          res_q.status  <= status_q;
          state_q       <= S_HOLD;
        end
        S_HOLD: begin
          if (res_rdy_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o     = res_q;
  assign res_vld_o = (state_q == S_HOLD);

endmodule

FILE: rtl/hit_plane_match_and_align_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hit_plane_match_and_align_unit: nearest-plane match and alignment correction
// Plane table in a chain of cells, followed by a shift/rotate corrector.
// ----------------------------------------------------------------------------
// Use:
//  - s_axis carries load and hit items; tuser is the action code. Loads fill
//    one slot of the plane table (id and z, offsets, angles) and are done in
//    the cycle they are accepted; they give no transfer on m_axis.
//  - A hit walks the chain of MAX_PLANES cells, one cell a cycle, each cell
//    keeping the nearer plane (lower slot wins a tie). The corrector then
//    checks the window and applies the plane's constants. The six rotation
//    products share one multiplier, one product a cycle.
//  - One hit is in flight at a time: s_axis_tready drops after a hit transfer
//    and returns once its result sits in the output register, so a new hit is
//    taken only after the last one's result has left the corrector. A result
//    waiting in the output register does not block input.
//  - cfg channel (always ready) writes mode, planes in use and match window;
//    the user must write it only while no hit is in flight (not enforced).
//  - Reset clears the per-slot offset flags, sets the config registers to their
//    defaults, clears all handshake state; table contents are undefined until loaded.
//  - If m_axis_tready stays low the result is held in the output register
//    and, behind it, in the corrector; s_axis then stays stalled.
// ----------------------------------------------------------------------------
module hit_plane_match_and_align_unit import hpma_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot[2:0], sensor_id[10:3], pos_x[38:11], pos_y[66:39], pos_z[94:67],
  // angle_alpha[118:95], angle_beta[142:119], angle_gamma[166:143], zero pad
  input  logic [167:0]          s_axis_tdata,
  // action[1:0]
  input  logic [1:0]            s_axis_tuser,
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_x[27:0], out_y[55:28], out_z[83:56], matched_sensor[91:84], zero pad
  output logic [95:0]           m_axis_tdata,
  // was_aligned[0], status[1]
  output logic [1:0]            m_axis_tuser
);

  corr_mode_e       mode_q;
  logic [PIU_W-1:0] planes_q;
  logic [WIN_W-1:0] window_q;

  logic             busy_q;
  logic             out_vld_q;
  hit_res_t         out_q;

  logic             in_xfer, hit_xfer, ld_xfer;
  action_e          act;
  logic [SLOT_W-1:0] slot;
  plane_ld_t        ld;
  hit_tok_t         tok [MAX_PLANES+1];
  hit_res_t         res;
  logic             res_vld, res_rdy, res_xfer;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ROT_SHIFT;
      planes_q <= PIU_W'(6);
      window_q <= WIN_W'(5120);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        CFG_MODE:   mode_q   <= corr_mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_PLANES: planes_q <= cfg_data_i[PIU_W-1:0];
        CFG_WINDOW: window_q <= cfg_data_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input decode
  assign s_axis_tready = !busy_q;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign act      = action_e'(s_axis_tuser);
  assign hit_xfer = in_xfer && act == ACT_HIT;
  assign ld_xfer  = in_xfer && act != ACT_HIT;
  assign slot     = s_axis_tdata[2:0];

  always_comb begin
    ld.action = act;
    ld.sensor = s_axis_tdata[10:3];
    ld.px     = s_axis_tdata[38:11];
    ld.py     = s_axis_tdata[66:39];
    ld.pz     = s_axis_tdata[94:67];
    ld.aa     = s_axis_tdata[118:95];
    ld.ab     = s_axis_tdata[142:119];
    ld.ag     = s_axis_tdata[166:143];

    tok[0]        = '0;
    tok[0].vld    = hit_xfer;
    tok[0].px     = ld.px;
    tok[0].py     = ld.py;
    tok[0].pz     = ld.pz;
  end

  // search chain: cell i owns slot i and is searched while i < planes in use
  for (genvar i = 0; i < MAX_PLANES; i++) begin : g_cell
    hpma_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .we_i   (ld_xfer && int'(slot) == i),
      .ld_i   (ld),
      .en_i   (int'(planes_q) > i),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  hpma_corr u_corr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tok_i     (tok[MAX_PLANES]),
    .mode_i    (mode_q),
    .window_i  (window_q),
    .res_o     (res),
    .res_vld_o (res_vld),
    .res_rdy_i (res_rdy)
  );

  // output register; frees the corrector while the receiver stalls
  assign res_rdy  = !out_vld_q || m_axis_tready;
  assign res_xfer = res_vld && res_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      busy_q    <= 1'b0;
    end else begin
      if (res_xfer) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (hit_xfer) begin
        busy_q <= 1'b1;
      end else if (res_xfer) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_xfer) out_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_q.sensor, out_q.z, out_q.y, out_q.x};
  assign m_axis_tuser  = {out_q.status, out_q.aligned};

`ifndef SYNTHESIS
  a_no_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !res_vld)
    else $error("corrector holds a result with no hit in flight");

  a_hit_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_xfer |=> !s_axis_tready)
    else $error("input still open after a hit transfer");

  a_far_not_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tuser[0])
    else $error("too-far hit reported as aligned");
`endif

endmodule
